### hw/rtl/tgd_pkg.sv
// Shared types and constants for the tile grid debounce block.
`timescale 1ns / 1ps
`default_nettype none

package tgd_pkg;

    localparam logic [1:0] CFG_ROWS_IN_USE     = 2'd0;
    localparam logic [1:0] CFG_COLS_IN_USE     = 2'd1;
    localparam logic [1:0] CFG_AGREE_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_HAND_GRACE_MS   = 2'd3;

    localparam logic [3:0]  RESET_ROWS_IN_USE     = 4'd5;
    localparam logic [4:0]  RESET_COLS_IN_USE     = 5'd9;
    localparam logic [7:0]  RESET_AGREE_THRESHOLD = 8'd2;
    localparam logic [15:0] RESET_HAND_GRACE_MS   = 16'd1000;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] obs;
        logic       fresh;
        logic       held;
        logic       rise;
        logic       in_range;
    } op_t;

    typedef struct packed {
        logic [1:0] stable;
        logic [1:0] cand;
        logic [7:0] count;
    } cell_t;

endpackage

`default_nettype wire

### hw/rtl/tgd_front.sv
// Front end: range check, code normalization and hand hold-off tracking.
`timescale 1ns / 1ps
`default_nettype none

module tgd_front
    import tgd_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [2:0]  cell_row,
    input  wire logic [3:0]  cell_col,
    input  wire logic [2:0]  seen_code,
    input  wire logic        hand_seen,
    input  wire logic [31:0] time_ms,
    input  wire logic        fresh,
    input  wire logic [3:0]  rows_in_use,
    input  wire logic [4:0]  cols_in_use,
    input  wire logic [15:0] hand_grace_ms,
    output op_t              op,
    output logic [((MAX_ROWS * MAX_COLS) > 1 ? $clog2(MAX_ROWS * MAX_COLS) : 1)-1:0] idx
);

    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int AW = CELL_COUNT > 1 ? $clog2(CELL_COUNT) : 1;

    logic        last_hand_reg;
    logic [31:0] hold_until_reg;
    logic [31:0] diff;
    logic [31:0] idx_wide;
    logic        row_ok;
    logic        col_ok;
    logic        ahead;

    assign row_ok = ({1'b0, cell_row} < rows_in_use) && (32'(cell_row) < 32'(MAX_ROWS));
    assign col_ok = ({1'b0, cell_col} < cols_in_use) && (32'(cell_col) < 32'(MAX_COLS));

    assign diff  = hold_until_reg - time_ms;
    assign ahead = (diff != 32'd0) && !diff[31];

    assign idx_wide = 32'(cell_row) * 32'(MAX_COLS) + 32'(cell_col);
    assign idx      = idx_wide[AW-1:0];

    always_comb
    begin
        op.obs      = ((seen_code >= 3'd1) && (seen_code <= 3'd3)) ? seen_code[1:0] : 2'd0;
        op.fresh    = fresh;
        op.held     = hand_seen || ahead;
        op.rise     = hand_seen && !last_hand_reg;
        op.in_range = row_ok && col_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_hand_reg  <= 1'b0;
            hold_until_reg <= 32'd0;
        end
        else if (accept && row_ok && col_ok)
        begin
            last_hand_reg <= hand_seen;
            if (hand_seen)
            begin
                hold_until_reg <= time_ms + {16'd0, hand_grace_ms};
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tgd_queue.sv
// Short first-in first-out queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module tgd_queue
    import tgd_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  not_full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign not_full  = count_reg != CW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tgd_back.sv
// Back end: cell memory, read-modify-write debounce update and result register.
`timescale 1ns / 1ps
`default_nettype none

module tgd_back
    import tgd_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  op_t              q_op,
    input  wire logic [((MAX_ROWS * MAX_COLS) > 1 ? $clog2(MAX_ROWS * MAX_COLS) : 1)-1:0] q_idx,
    output logic             q_pop,
    output logic             clearing,
    input  wire logic [7:0]  agree_threshold,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       stable_code,
    output logic             stable_changed,
    output logic             held_off,
    output logic             hand_rise,
    output logic             in_range
);

    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int AW = CELL_COUNT > 1 ? $clog2(CELL_COUNT) : 1;

    cell_t         mem [CELL_COUNT];
    cell_t         rd_data_reg;
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          s1_valid_reg;
    op_t           s1_op_reg;
    logic [AW-1:0] s1_idx_reg;
    logic          lw_valid_reg;
    logic [AW-1:0] lw_addr_reg;
    cell_t         lw_data_reg;
    logic          out_valid_reg;
    logic [1:0]    stable_code_reg;
    logic          stable_changed_reg;
    logic          held_off_reg;
    logic          hand_rise_reg;
    logic          in_range_reg;

    cell_t cur;
    cell_t nxt;
    logic  wr_en;
    logic  changed;
    logic  s1_adv;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop    = q_valid && !clearing_reg && (!s1_valid_reg || s1_adv);
    assign clearing = clearing_reg;

    assign cur = (lw_valid_reg && (lw_addr_reg == s1_idx_reg)) ? lw_data_reg : rd_data_reg;

    always_comb
    begin
        nxt     = cur;
        wr_en   = 1'b0;
        changed = 1'b0;
        if (s1_op_reg.in_range)
        begin
            if (s1_op_reg.held)
            begin
                wr_en     = 1'b1;
                nxt.count = 8'd0;
                if (s1_op_reg.fresh)
                begin
                    nxt.cand = s1_op_reg.obs;
                end
            end
            else if (s1_op_reg.fresh)
            begin
                wr_en = 1'b1;
                if (cur.cand != s1_op_reg.obs)
                begin
                    nxt.cand  = s1_op_reg.obs;
                    nxt.count = 8'd1;
                end
                else if (cur.count != COUNT_MAX)
                begin
                    nxt.count = cur.count + 8'd1;
                end
                if ((cur.stable != s1_op_reg.obs) && (nxt.count >= agree_threshold))
                begin
                    nxt.stable = s1_op_reg.obs;
                    changed    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (s1_adv && wr_en)
        begin
            mem[s1_idx_reg] <= nxt;
        end
        if (q_pop)
        begin
            rd_data_reg <= mem[q_idx];
            s1_op_reg   <= q_op;
            s1_idx_reg  <= q_idx;
        end
        if (s1_adv && wr_en)
        begin
            lw_addr_reg <= s1_idx_reg;
            lw_data_reg <= nxt;
        end
        if (s1_adv)
        begin
            stable_code_reg    <= s1_op_reg.in_range ? nxt.stable : 2'd0;
            stable_changed_reg <= changed;
            held_off_reg       <= s1_op_reg.in_range && s1_op_reg.held;
            hand_rise_reg      <= s1_op_reg.in_range && s1_op_reg.rise;
            in_range_reg       <= s1_op_reg.in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_addr_reg == AW'(CELL_COUNT - 1))
                begin
                    clearing_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end
            if (q_pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv && wr_en)
            begin
                lw_valid_reg <= 1'b1;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign stable_code    = stable_code_reg;
    assign stable_changed = stable_changed_reg;
    assign held_off       = held_off_reg;
    assign hand_rise      = hand_rise_reg;
    assign in_range       = in_range_reg;

endmodule

`default_nettype wire

### hw/rtl/tile_grid_debounce_with_hand_hold_top.sv
// Top level of the tile grid debounce block with hand hold-off.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    cell_row, cell_col, seen_code, hand_seen,
//                                           time_ms, fresh
// out       output     out_valid/out_ready  stable_code, stable_changed, held_off,
//                                           hand_rise, in_range
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_ready is high; the outputs are registered.
// The rate is set by the single read and write port of the cell memory, whose read is
// forwarded from the last write so that back-to-back updates of one cell stay correct.
// After reset a clearing pass over all MAX_ROWS * MAX_COLS cells zeroes the cell memory, and
// in_ready stays low during it. A stalled output fills the two-entry queue, then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module tile_grid_debounce_with_hand_hold_top
    import tgd_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cell_row,
    input  wire logic [3:0]  cell_col,
    input  wire logic [2:0]  seen_code,
    input  wire logic        hand_seen,
    input  wire logic [31:0] time_ms,
    input  wire logic        fresh,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       stable_code,
    output logic             stable_changed,
    output logic             held_off,
    output logic             hand_rise,
    output logic             in_range,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int AW = CELL_COUNT > 1 ? $clog2(CELL_COUNT) : 1;
    localparam int QW = AW + $bits(op_t);

    logic [3:0]  rows_in_use_reg;
    logic [4:0]  cols_in_use_reg;
    logic [7:0]  agree_threshold_reg;
    logic [15:0] hand_grace_ms_reg;

    op_t           f_op;
    logic [AW-1:0] f_idx;
    logic          accept;
    logic          q_not_full;
    logic          q_not_empty;
    logic          q_pop;
    logic [QW-1:0] q_data;
    op_t           q_op;
    logic [AW-1:0] q_idx;
    logic          clearing;

    assign cfg_ready = 1'b1;
    assign in_ready  = q_not_full && !clearing;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg     <= RESET_ROWS_IN_USE;
            cols_in_use_reg     <= RESET_COLS_IN_USE;
            agree_threshold_reg <= RESET_AGREE_THRESHOLD;
            hand_grace_ms_reg   <= RESET_HAND_GRACE_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROWS_IN_USE:     rows_in_use_reg     <= cfg_data[3:0];
                CFG_COLS_IN_USE:     cols_in_use_reg     <= cfg_data[4:0];
                CFG_AGREE_THRESHOLD: agree_threshold_reg <= cfg_data[7:0];
                CFG_HAND_GRACE_MS:   hand_grace_ms_reg   <= cfg_data;
            endcase
        end
    end

    tgd_front #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .seen_code    (seen_code),
        .hand_seen    (hand_seen),
        .time_ms      (time_ms),
        .fresh        (fresh),
        .rows_in_use  (rows_in_use_reg),
        .cols_in_use  (cols_in_use_reg),
        .hand_grace_ms(hand_grace_ms_reg),
        .op           (f_op),
        .idx          (f_idx)
    );

    tgd_queue #(
        .WIDTH(QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_data({f_idx, f_op}),
        .not_full (q_not_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .pop_data (q_data)
    );

    assign q_idx = q_data[QW-1:$bits(op_t)];
    assign q_op  = q_data[$bits(op_t)-1:0];

    tgd_back #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_not_empty),
        .q_op           (q_op),
        .q_idx          (q_idx),
        .q_pop          (q_pop),
        .clearing       (clearing),
        .agree_threshold(agree_threshold_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .stable_code    (stable_code),
        .stable_changed (stable_changed),
        .held_off       (held_off),
        .hand_rise      (hand_rise),
        .in_range       (in_range)
    );

endmodule

`default_nettype wire
